// ----- src/ilt_pkg.sv -----
// Shared types and codes for the INI line tokenizer.
// Used by ilt_front, ilt_back and ini_line_tokenizer_core; depends on nothing.
`default_nettype none

package ilt_pkg;

    // Byte classes produced by the front end
    typedef enum logic [2:0] {
        CLS_OTHER   = 3'd0,
        CLS_SPACE   = 3'd1,
        CLS_COMMENT = 3'd2,
        CLS_EQUALS  = 3'd3,
        CLS_LBR     = 3'd4,
        CLS_RBR     = 3'd5,
        CLS_QUOTE   = 3'd6,
        CLS_NEWLINE = 3'd7
    } t_cls;

    // One queued beat: classified byte plus end-of-file marker
    typedef struct packed {
        t_cls cls;
        logic last;
    } t_item;

    // Line parse modes
    typedef enum logic [3:0] {
        MODE_START = 4'b0001,
        MODE_NAME  = 4'b0010,
        MODE_VALUE = 4'b0100,
        MODE_SKIP  = 4'b1000
    } t_mode;

    // Line kinds
    localparam logic [1:0] KIND_PLAIN     = 2'd0;
    localparam logic [1:0] KIND_SECTION   = 2'd1;
    localparam logic [1:0] KIND_PROPERTY  = 2'd2;
    localparam logic [1:0] KIND_MALFORMED = 2'd3;

    localparam logic [11:0] FIELD_MAX = 12'hFFF;
    localparam logic [12:0] LEN_MAX   = 13'h1FFF;

    typedef struct packed {
        logic [1:0]  kind;
        logic [12:0] line_length;
        logic [11:0] name_offset;
        logic [11:0] name_length;
        logic [11:0] value_offset;
        logic [11:0] value_length;
        logic        end_of_input;
    } t_result;

endpackage

`default_nettype wire

// ----- src/ilt_front.sv -----
// Front end of the INI line tokenizer: byte classifier and a short queue.
// Depends on ilt_pkg.
`default_nettype none

module ilt_front
    import ilt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [7:0] i_byte_value,
    input  wire logic       i_last_byte,
    output logic            o_in_stall,
    output logic            o_q_valid,
    output t_item           o_q_item,
    input  wire logic       i_q_pop
);

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_LBR     = 8'h5B;
    localparam logic [7:0] CH_RBR     = 8'h5D;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    t_item          r_mem [QDEPTH];
    logic [QAW-1:0] r_wr, n_wr;
    logic [QAW-1:0] r_rd, n_rd;
    logic [QAW:0]   r_cnt, n_cnt;
    t_item          w_item;
    logic           w_push;

    always_comb begin
        w_item.last = i_last_byte;
        if (i_byte_value == CH_NEWLINE) begin
            w_item.cls = CLS_NEWLINE;
        end else if (i_byte_value == CH_HASH || i_byte_value == CH_SEMI) begin
            w_item.cls = CLS_COMMENT;
        end else if (i_byte_value == CH_EQUALS) begin
            w_item.cls = CLS_EQUALS;
        end else if (i_byte_value == CH_LBR) begin
            w_item.cls = CLS_LBR;
        end else if (i_byte_value == CH_RBR) begin
            w_item.cls = CLS_RBR;
        end else if (i_byte_value == CH_QUOTE) begin
            w_item.cls = CLS_QUOTE;
        end else if (i_byte_value inside {[8'h09:8'h0D], 8'h20}) begin
            w_item.cls = CLS_SPACE;
        end else begin
            w_item.cls = CLS_OTHER;
        end
    end

    assign o_in_stall = (r_cnt == (QAW+1)'(QDEPTH));
    assign w_push     = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_cnt != '0);
    assign o_q_item   = r_mem[r_rd];

    always_comb begin
        n_wr  = w_push ? r_wr + 1'b1 : r_wr;
        n_rd  = i_q_pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + (QAW+1)'(w_push) - (QAW+1)'(i_q_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= w_item;
        end
    end

endmodule

`default_nettype wire

// ----- src/ilt_back.sv -----
// Back end of the INI line tokenizer: line state machine and result builder.
// Depends on ilt_pkg.
`default_nettype none

module ilt_back
    import ilt_pkg::*;
#(
    parameter int LINE_MAX = 4096
)
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_fire,
    input  wire t_item i_item,
    output logic       o_emit,
    output t_result    o_result
);

    localparam int PW = $clog2(LINE_MAX + 1);
    localparam int XW = (PW > 13) ? PW : 13;

    t_mode          r_mode, n_mode;
    logic           r_iq, n_iq, r_qs, n_qs, r_ib, n_ib;
    logic           r_sec, n_sec, r_eq, n_eq, r_bad, n_bad;
    logic [PW-1:0]  r_pos, n_pos;
    logic [PW-1:0]  r_nb, n_nb, r_nf, n_nf, r_vb, n_vb, r_vf, n_vf;
    logic           r_nbok, n_nbok, r_nfok, n_nfok, r_vbok, n_vbok, r_vfok, n_vfok;
    logic           w_over, w_nl, w_bad_out, w_clear;
    t_mode          w_proc;
    logic [1:0]     w_kind;
    logic [PW-1:0]  w_no, w_nl_len, w_vo, w_vl;

    function automatic logic [11:0] sat12(input logic [PW-1:0] v);
        logic [XW-1:0] w;
        w = XW'(v);
        sat12 = (w > XW'(FIELD_MAX)) ? FIELD_MAX : w[11:0];
    endfunction

    function automatic logic [12:0] sat13(input logic [PW-1:0] v);
        logic [XW-1:0] w;
        w = XW'(v);
        sat13 = (w > XW'(LEN_MAX)) ? LEN_MAX : w[12:0];
    endfunction

    always_comb begin
        n_mode = r_mode; n_iq = r_iq; n_qs = r_qs; n_ib = r_ib;
        n_sec = r_sec; n_eq = r_eq; n_bad = r_bad; n_pos = r_pos;
        n_nb = r_nb; n_nf = r_nf; n_vb = r_vb; n_vf = r_vf;
        n_nbok = r_nbok; n_nfok = r_nfok; n_vbok = r_vbok; n_vfok = r_vfok;
        w_nl = (i_item.cls == CLS_NEWLINE);
        w_proc = MODE_SKIP;

        // overlong line: stick at the limit and skip to newline
        w_over = (r_pos >= PW'(LINE_MAX));
        if (w_over) begin
            n_bad  = 1'b1;
            n_mode = MODE_SKIP;
        end else begin
            n_pos = r_pos + 1'b1;
        end

        if (!w_nl) begin
            w_proc = n_mode;
            if (n_mode == MODE_START) begin
                case (i_item.cls)
                    CLS_COMMENT: n_mode = MODE_SKIP;
                    CLS_EQUALS: begin
                        if (n_eq) begin
                            n_bad  = 1'b1;
                            n_mode = MODE_SKIP;
                        end else begin
                            n_eq = 1'b1;
                        end
                    end
                    CLS_SPACE: ;
                    default: begin
                        n_mode = n_eq ? MODE_VALUE : MODE_NAME;
                        w_proc = n_mode;
                    end
                endcase
            end

            if (w_proc == MODE_NAME) begin
                if (r_iq) begin
                    n_nf   = r_pos;
                    n_nfok = 1'b1;
                    if (i_item.cls == CLS_QUOTE) begin
                        n_iq = 1'b0;
                    end
                end else begin
                    case (i_item.cls)
                        CLS_COMMENT: begin
                            n_bad = 1'b1; n_mode = MODE_SKIP;
                        end
                        CLS_LBR: begin
                            if (r_nbok || r_ib) begin
                                n_bad = 1'b1; n_mode = MODE_SKIP;
                            end else begin
                                n_ib = 1'b1;
                            end
                        end
                        CLS_RBR: begin
                            if (!r_nbok || !r_ib) begin
                                n_bad = 1'b1; n_mode = MODE_SKIP;
                            end else begin
                                n_ib = 1'b0; n_sec = 1'b1;
                            end
                        end
                        CLS_QUOTE: begin
                            if (r_nbok || r_qs) begin
                                n_bad = 1'b1; n_mode = MODE_SKIP;
                            end else begin
                                n_qs = 1'b1; n_iq = 1'b1;
                                n_nb = r_pos + 1'b1; n_nbok = 1'b1;
                            end
                        end
                        CLS_EQUALS: begin
                            if (r_ib) begin
                                n_bad = 1'b1; n_mode = MODE_SKIP;
                            end else begin
                                n_eq = 1'b1; n_qs = 1'b0; n_mode = MODE_START;
                            end
                        end
                        CLS_SPACE: ;
                        default: begin
                            if (r_qs) begin
                                n_bad = 1'b1; n_mode = MODE_SKIP;
                            end else begin
                                if (!r_nbok) begin
                                    n_nb = r_pos; n_nbok = 1'b1;
                                end
                                n_nf = r_pos + 1'b1; n_nfok = 1'b1;
                            end
                        end
                    endcase
                end
            end else if (w_proc == MODE_VALUE) begin
                if (r_iq) begin
                    n_vf   = r_pos;
                    n_vfok = 1'b1;
                    if (i_item.cls == CLS_QUOTE) begin
                        n_iq = 1'b0;
                    end
                end else begin
                    case (i_item.cls)
                        CLS_COMMENT: n_mode = MODE_SKIP;
                        CLS_QUOTE: begin
                            if (r_vbok || r_qs) begin
                                n_bad = 1'b1; n_mode = MODE_SKIP;
                            end else begin
                                n_qs = 1'b1; n_iq = 1'b1;
                                n_vb = r_pos + 1'b1; n_vbok = 1'b1;
                            end
                        end
                        CLS_EQUALS: begin
                            n_bad = 1'b1; n_mode = MODE_SKIP;
                        end
                        CLS_SPACE: ;
                        default: begin
                            if (r_qs) begin
                                n_bad = 1'b1; n_mode = MODE_SKIP;
                            end else begin
                                if (!r_vbok) begin
                                    n_vb = r_pos; n_vbok = 1'b1;
                                end
                                n_vf = r_pos + 1'b1; n_vfok = 1'b1;
                            end
                        end
                    endcase
                end
            end
        end

        // newline with an open quote or bracket marks the line malformed
        w_bad_out = n_bad;
        if (w_nl) begin
            if (n_mode == MODE_NAME && (n_iq || n_ib)) begin
                w_bad_out = 1'b1;
            end else if (n_mode == MODE_VALUE && n_iq) begin
                w_bad_out = 1'b1;
            end
        end

        if (w_bad_out) begin
            w_kind = KIND_MALFORMED;
        end else if (n_eq) begin
            w_kind = KIND_PROPERTY;
        end else if (n_sec) begin
            w_kind = KIND_SECTION;
        end else begin
            w_kind = KIND_PLAIN;
        end

        w_no = '0; w_nl_len = '0; w_vo = '0; w_vl = '0;
        if ((w_kind == KIND_SECTION || w_kind == KIND_PROPERTY) && n_nbok && n_nfok) begin
            w_no     = n_nb;
            w_nl_len = (n_nf > n_nb) ? n_nf - n_nb : '0;
        end
        if (w_kind == KIND_PROPERTY && n_vbok && n_vfok) begin
            w_vo = n_vb;
            w_vl = (n_vf > n_vb) ? n_vf - n_vb : '0;
        end

        w_clear = w_nl || i_item.last;
        o_emit  = w_clear;
        o_result.kind         = w_kind;
        o_result.line_length  = sat13(n_pos);
        o_result.name_offset  = sat12(w_no);
        o_result.name_length  = sat12(w_nl_len);
        o_result.value_offset = sat12(w_vo);
        o_result.value_length = sat12(w_vl);
        o_result.end_of_input = i_item.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && w_clear)) begin
            r_mode <= MODE_START;
            r_iq <= 1'b0; r_qs <= 1'b0; r_ib <= 1'b0;
            r_sec <= 1'b0; r_eq <= 1'b0; r_bad <= 1'b0;
            r_pos <= '0;
            r_nb <= '0; r_nf <= '0; r_vb <= '0; r_vf <= '0;
            r_nbok <= 1'b0; r_nfok <= 1'b0; r_vbok <= 1'b0; r_vfok <= 1'b0;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_iq <= n_iq; r_qs <= n_qs; r_ib <= n_ib;
            r_sec <= n_sec; r_eq <= n_eq; r_bad <= n_bad;
            r_pos <= n_pos;
            r_nb <= n_nb; r_nf <= n_nf; r_vb <= n_vb; r_vf <= n_vf;
            r_nbok <= n_nbok; r_nfok <= n_nfok; r_vbok <= n_vbok; r_vfok <= n_vfok;
        end
    end

endmodule

`default_nettype wire

// ----- src/ini_line_tokenizer_core.sv -----
// INI line tokenizer, top level: front classifier/queue, back parser, output register.
// Depends on ilt_pkg, ilt_front and ilt_back.
//
// Input channel: one byte of INI text per beat on i_byte_value, i_last_byte high
//   on the final byte of a file; a beat is taken when i_in_valid is high and
//   o_in_stall is low.
// Output channel: one line descriptor per beat (kind, length, name and value
//   spans, end-of-input flag), taken when o_out_valid is high and i_out_stall low.
//   A result appears for every newline byte, and for the final byte of a file
//   when that byte is not itself a newline.
// Timing: one byte per cycle sustained while the receiver does not stall. A byte
//   is written into the queue and parsed as it leaves, straight into the output
//   register, which then holds the result of the line that the byte ends.
// Stall: while the receiver stalls, the held result stays put and the back end
//   stops; the four-beat queue keeps taking bytes until it fills, and only then
//   is o_in_stall raised.
// Reset: synchronous, active low: empty the queue, drop any held result and
//   return the line state to line start.
`default_nettype none

module ini_line_tokenizer_core
    import ilt_pkg::*;
#(
    parameter int LINE_MAX = 4096
)
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_byte_value,
    input  wire logic        i_last_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_line_kind,
    output logic [12:0]      o_line_length,
    output logic [11:0]      o_name_offset,
    output logic [11:0]      o_name_length,
    output logic [11:0]      o_value_offset,
    output logic [11:0]      o_value_length,
    output logic             o_end_of_input
);

    logic    w_q_valid;
    t_item   w_q_item;
    logic    w_fire;
    logic    w_emit;
    t_result w_result;
    logic    r_out_valid, n_out_valid;
    t_result r_out;
    logic    w_out_free;

    ilt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_byte_value (i_byte_value),
        .i_last_byte  (i_last_byte),
        .o_in_stall   (o_in_stall),
        .o_q_valid    (w_q_valid),
        .o_q_item     (w_q_item),
        .i_q_pop      (w_fire)
    );

    ilt_back #(
        .LINE_MAX (LINE_MAX)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (w_q_item),
        .o_emit   (w_emit),
        .o_result (w_result)
    );

    // advance the back end only when the output slot is empty or being taken
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_fire     = w_q_valid && w_out_free;

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_fire && w_emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // hold the result payload until a new one is loaded
    always_ff @(posedge i_clk) begin
        if (w_fire && w_emit) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_line_kind    = r_out.kind;
    assign o_line_length  = r_out.line_length;
    assign o_name_offset  = r_out.name_offset;
    assign o_name_length  = r_out.name_length;
    assign o_value_offset = r_out.value_offset;
    assign o_value_length = r_out.value_length;
    assign o_end_of_input = r_out.end_of_input;

`ifndef ASSERT_OFF
    // a section line never carries a value span
    a_section_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_line_kind == KIND_SECTION
        |-> o_value_offset == 12'd0 && o_value_length == 12'd0)
        else $error("section line reports a value span");

    // plain and malformed lines carry no spans at all
    a_plain_no_spans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_line_kind == KIND_PLAIN || o_line_kind == KIND_MALFORMED)
        |-> o_name_offset == 12'd0 && o_name_length == 12'd0
            && o_value_offset == 12'd0 && o_value_length == 12'd0)
        else $error("plain or malformed line reports a span");

    // every emitted line holds at least one byte and no more than the limit
    a_length_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_line_length != 13'd0
            && 32'(o_line_length) <= LINE_MAX)
        else $error("line length out of range");
`endif

endmodule

`default_nettype wire
